### rtl/core/dsad_pkg.sv
`timescale 1ns / 1ps
// Package for the differential sine/cosine angle decoder.
// Holds the beat types, fixed-point widths and the arctangent table; depends on nothing.
package dsad_pkg;

    localparam int DEF_CORDIC_STAGES   = 16;
    localparam int DEF_ANGLE_FRAC_BITS = 6;
    localparam int MAX_STAGES          = 24;

    localparam int MV_W     = 13;
    localparam int DIFF_W   = MV_W + 1;
    localparam int IN_FRAC  = 16;
    localparam int DATA_W   = 34;
    localparam int ZW       = 27;
    localparam int ATAN_W   = 23;
    localparam int ANGLE_W  = 15;

    localparam logic signed [ZW-1:0] Z_90      = 27'sd5898240;
    localparam logic        [ZW-1:0] FULL_TURN = 27'd23592960;

    typedef struct packed {
        logic [MV_W-1:0] sin_pos_mv;
        logic [MV_W-1:0] sin_neg_mv;
        logic [MV_W-1:0] cos_pos_mv;
        logic [MV_W-1:0] cos_neg_mv;
        logic            sample_valid;
    } sample_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_deg_q6;
        logic               angle_valid;
    } angle_t;

    // atan(2^-idx) in degrees, scaled by 2^16 and rounded to nearest.
    function automatic logic [ATAN_W-1:0] atan_q16(input int unsigned idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            0:       v = 23'd2949120;
            1:       v = 23'd1740967;
            2:       v = 23'd919879;
            3:       v = 23'd466945;
            4:       v = 23'd234379;
            5:       v = 23'd117304;
            6:       v = 23'd58666;
            7:       v = 23'd29335;
            8:       v = 23'd14668;
            9:       v = 23'd7334;
            10:      v = 23'd3667;
            11:      v = 23'd1833;
            12:      v = 23'd917;
            13:      v = 23'd458;
            14:      v = 23'd229;
            15:      v = 23'd115;
            16:      v = 23'd57;
            17:      v = 23'd29;
            18:      v = 23'd14;
            19:      v = 23'd7;
            20:      v = 23'd4;
            21:      v = 23'd2;
            22:      v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/differential_sincos_angle_decoder_core.sv
`timescale 1ns / 1ps
// Differential sine/cosine angle decoder: pipelined vectoring CORDIC atan2.
// Depends on dsad_pkg for beat types, widths and the arctangent table.
//
//   Channel | Handshake            | Payload           | Beat
//   --------+----------------------+-------------------+---------------------------------
//   sample  | smp_valid, smp_ready | smp (sample_t)    | four channel voltages and a flag
//   angle   | ang_valid, ang_ready | ang (angle_t)     | angle in 1/64 degree and a flag
//
// One beat enters per cycle unless a stalled output has filled every stage. One stage
// forms the differences and the quadrant pre-rotation, one per CORDIC micro-rotation,
// one stage folds negative angles into the full turn and one rounds and wraps into the
// output register. Reset clears only the stage valid bits. Each stage loads whenever it
// is empty or the stage after it moves, so a stalled output holds its beat while
// earlier bubbles still fill; nothing is dropped or repeated.
module differential_sincos_angle_decoder_core #(
    parameter int CORDIC_STAGES   = dsad_pkg::DEF_CORDIC_STAGES,
    parameter int ANGLE_FRAC_BITS = dsad_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              smp_valid,
    output logic              smp_ready,
    input  dsad_pkg::sample_t smp,
    output logic              ang_valid,
    input  logic              ang_ready,
    output dsad_pkg::angle_t  ang
);

    localparam int DATA_W  = dsad_pkg::DATA_W;
    localparam int ZW      = dsad_pkg::ZW;
    localparam int DIFF_W  = dsad_pkg::DIFF_W;
    localparam int PW      = DIFF_W + 1;
    localparam int IN_FRAC = dsad_pkg::IN_FRAC;
    // Pipeline: pre-rotation, the micro-rotations, fold, output.
    localparam int LAST    = CORDIC_STAGES + 2;
    localparam int SHIFT   = IN_FRAC - ANGLE_FRAC_BITS;
    localparam logic [ZW-1:0] HALF   = ZW'(1) << (SHIFT - 1);
    localparam logic [ZW-1:0] FULL_Q = ZW'(360) << ANGLE_FRAC_BITS;

    // Stage valid bits and the load enables that ripple back from the output.
    logic vld_reg [0:LAST];
    logic adv     [0:LAST];

    // CORDIC vector and angle accumulator; entry 0 is after pre-rotation,
    // entry i+1 after micro-rotation i.
    logic signed [DATA_W-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [DATA_W-1:0] y_reg [0:CORDIC_STAGES];
    logic signed [ZW-1:0]     z_reg [0:CORDIC_STAGES];
    // Sample flag and the both-differences-zero mark, carried alongside.
    logic sv_reg [0:CORDIC_STAGES+1];
    logic zr_reg [0:CORDIC_STAGES+1];

    logic [ZW-1:0]     zp_reg;
    dsad_pkg::angle_t  out_reg;

    assign adv[LAST] = !vld_reg[LAST] || ang_ready;

    genvar k;
    generate
        for (k = 0; k < LAST; k++)
        begin : g_ready
            assign adv[k] = !vld_reg[k] || adv[k+1];
        end

        for (k = 0; k <= LAST; k++)
        begin : g_valid
            logic vld_in;

            // The first stage takes the input flag, every later one its predecessor.
            if (k == 0)
            begin : g_head
                assign vld_in = smp_valid;
            end
            else
            begin : g_tail
                assign vld_in = vld_reg[k-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (adv[k])
                begin
                    vld_reg[k] <= vld_in;
                end
            end
        end
    endgenerate

    assign smp_ready = adv[0];
    assign ang_valid = vld_reg[LAST];
    assign ang       = out_reg;

    // Differences and pre-rotation. The vertical part is the negated sine difference.
    logic signed [DIFF_W-1:0] y_d;
    logic signed [DIFF_W-1:0] x_d;
    logic signed [PW-1:0]     x_e;
    logic signed [PW-1:0]     y_e;
    logic signed [PW-1:0]     x_p;
    logic signed [PW-1:0]     y_p;
    logic signed [ZW-1:0]     z_p;

    always_comb
    begin
        y_d = DIFF_W'({1'b0, smp.sin_neg_mv}) - DIFF_W'({1'b0, smp.sin_pos_mv});
        x_d = DIFF_W'({1'b0, smp.cos_pos_mv}) - DIFF_W'({1'b0, smp.cos_neg_mv});
        x_e = {x_d[DIFF_W-1], x_d};
        y_e = {y_d[DIFF_W-1], y_d};
        x_p = x_e;
        y_p = y_e;
        z_p = '0;
        // Left half-plane: turn by a quarter so the vector starts with x >= 0.
        if (x_e[PW-1])
        begin
            if (!y_e[PW-1])
            begin
                x_p = y_e;
                y_p = -x_e;
                z_p = dsad_pkg::Z_90;
            end
            else
            begin
                x_p = -y_e;
                y_p = x_e;
                z_p = -dsad_pkg::Z_90;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            x_reg[0]  <= {{(DATA_W-PW-IN_FRAC){x_p[PW-1]}}, x_p, {IN_FRAC{1'b0}}};
            y_reg[0]  <= {{(DATA_W-PW-IN_FRAC){y_p[PW-1]}}, y_p, {IN_FRAC{1'b0}}};
            z_reg[0]  <= z_p;
            sv_reg[0] <= smp.sample_valid;
            zr_reg[0] <= (x_d == '0) && (y_d == '0);
        end
    end

    // One micro-rotation per stage; the shift amount is fixed by the stage position.
    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_cordic
            logic signed [DATA_W-1:0] xs;
            logic signed [DATA_W-1:0] ys;
            logic signed [ZW-1:0]     at;

            assign xs = x_reg[i] >>> i;
            assign ys = y_reg[i] >>> i;
            assign at = $signed({{(ZW-dsad_pkg::ATAN_W){1'b0}}, dsad_pkg::atan_q16(i)});

            always_ff @(posedge clk)
            begin
                if (adv[i+1])
                begin
                    if (!y_reg[i][DATA_W-1])
                    begin
                        x_reg[i+1] <= x_reg[i] + ys;
                        y_reg[i+1] <= y_reg[i] - xs;
                        z_reg[i+1] <= z_reg[i] + at;
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - ys;
                        y_reg[i+1] <= y_reg[i] + xs;
                        z_reg[i+1] <= z_reg[i] - at;
                    end
                    sv_reg[i+1] <= sv_reg[i];
                    zr_reg[i+1] <= zr_reg[i];
                end
            end
        end
    endgenerate

    // Fold a negative angle into [0, 360) degrees.
    always_ff @(posedge clk)
    begin
        if (adv[CORDIC_STAGES+1])
        begin
            if (z_reg[CORDIC_STAGES][ZW-1])
            begin
                zp_reg <= ZW'(z_reg[CORDIC_STAGES]) + dsad_pkg::FULL_TURN;
            end
            else
            begin
                zp_reg <= ZW'(z_reg[CORDIC_STAGES]);
            end
            sv_reg[CORDIC_STAGES+1] <= sv_reg[CORDIC_STAGES];
            zr_reg[CORDIC_STAGES+1] <= zr_reg[CORDIC_STAGES];
        end
    end

    // Round to the output resolution; a value that rounds up to a full turn wraps to 0.
    logic [ZW-1:0] rnd;
    logic [ZW-1:0] q_r;
    logic [ZW-1:0] q_w;

    always_comb
    begin
        rnd = zp_reg + HALF;
        q_r = rnd >> SHIFT;
        q_w = (q_r >= FULL_Q) ? (q_r - FULL_Q) : q_r;
    end

    always_ff @(posedge clk)
    begin
        if (adv[LAST])
        begin
            out_reg.angle_valid <= sv_reg[CORDIC_STAGES+1];
            if (!sv_reg[CORDIC_STAGES+1] || zr_reg[CORDIC_STAGES+1])
            begin
                out_reg.angle_deg_q6 <= '0;
            end
            else
            begin
                out_reg.angle_deg_q6 <= q_w[dsad_pkg::ANGLE_W-1:0];
            end
        end
    end

`ifndef ASSERT_OFF
    // A free output side means every stage can move, so the input must be open.
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        ang_ready |-> smp_ready)
        else $error("input closed while the output side is free");

    // A beat from a garbled sample carries angle zero.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ang_valid && !ang.angle_valid) |-> (ang.angle_deg_q6 == '0))
        else $error("invalid beat carries a non-zero angle");

    // An empty first stage stays empty unless a beat is taken in.
    a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!vld_reg[0] && !smp_valid) |=> !vld_reg[0])
        else $error("first stage filled without an input beat");
`endif

endmodule
